@@ hdl/stq_pkg.sv @@
package stq_pkg;

  localparam int SLOT_W    = 6;
  localparam int MAX_FIRED = 32;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_BIND  = 3'd2;
  localparam logic [2:0] KIND_ARM   = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [1:0] SLOT_FREE  = 2'd0;
  localparam logic [1:0] SLOT_ALLOC = 2'd1;
  localparam logic [1:0] SLOT_ARMED = 2'd2;

  localparam logic [5:0] TASK_NONE = 6'd32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  timer_slot;
    logic [31:0] payload;
    logic [1:0]  dest_queue;
    logic [31:0] delay;
  } stq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  slot_out;
    logic        fired;
    logic [31:0] fired_payload;
    logic [1:0]  fired_queue;
    logic        switch_req;
    logic        last;
  } stq_out_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       expiry;
  } stq_entry_t;

  typedef struct packed {
    logic       ins;
    logic       pop;
    stq_entry_t new_ent;
  } stq_ctl_t;

endpackage

@@ hdl/stq_ram.sv @@
module stq_ram #(
  parameter int W = 34,
  parameter int D = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/stq_cell.sv @@
module stq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stq_pkg::stq_ctl_t   ctl_i,
  input  stq_pkg::stq_entry_t left_i,
  input  logic                left_ge_i,
  input  stq_pkg::stq_entry_t right_i,
  output stq_pkg::stq_entry_t ent_o,
  output logic                ge_o
);
  import stq_pkg::*;

  stq_entry_t ent_q, ent_d;

  // at or after the new expiry, or empty: this cell moves down on insert
  assign ge_o = !ent_q.vld || (ent_q.expiry >= ctl_i.new_ent.expiry);

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.pop) begin
      ent_d = right_i;
    end else if (ctl_i.ins && ge_o) begin
      ent_d = left_ge_i ? left_i : ctl_i.new_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;
endmodule

@@ hdl/sorted_timer_queue_core.sv @@
// Sorted one-shot timer pool. Requests on in_req_i allocate, free, bind, arm
// or tick; each gives one result on out_res_o, a tick gives one result per
// delivered timer then a final one with last set. Armed timers sit in a row
// of cells kept in expiry order, head at cell 0; an arm inserts in place,
// ties go ahead of older entries. Non-tick requests produce their result the
// cycle after acceptance. A tick pops each due timer at the head, then reads
// its payload from the payload RAM (separate read and write ports); a task
// timer pop only sets switch_req; up to 32 deliveries per tick. A new request
// is taken only when the sequencer is idle and the output register is empty.
// task_timer_slot is written on the cfg channel (always ready); 32 or any
// slot at or above NUM_TIMERS means no task timer.
module sorted_timer_queue_core #(
  parameter int NUM_TIMERS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  stq_pkg::stq_in_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stq_pkg::stq_out_t out_res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [5:0]       cfg_data_i
);
  import stq_pkg::*;

  localparam int SW = $clog2(NUM_TIMERS);

  typedef enum logic [2:0] {S_IDLE, S_POP, S_EMIT, S_FINAL} state_e;

  state_e            state_q;
  logic [1:0]        slot_st_q [NUM_TIMERS];
  logic [31:0]       count_q;
  logic [5:0]        nfire_q;
  logic              ts_q;
  logic [5:0]        task_q;
  logic [SW-1:0]     fire_slot_q;
  logic              out_valid_q;
  stq_out_t          out_q;
  stq_out_t          out_d;
  logic              out_load;

  stq_ctl_t          ctl;
  stq_entry_t        ent   [NUM_TIMERS];
  logic              ge    [NUM_TIMERS];
  stq_entry_t        head;
  logic [33:0]       rdata;

  logic              acc, out_free, slot_ok, free_found, head_hit, head_task, do_fire;
  logic [SW-1:0]     sidx, free_idx;
  logic [1:0]        cur_st;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign acc         = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  assign sidx    = SW'(in_req_i.timer_slot);
  assign slot_ok = 32'(in_req_i.timer_slot) < NUM_TIMERS;
  assign cur_st  = slot_st_q[sidx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (slot_st_q[i] == SLOT_FREE) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign head      = ent[0];
  assign head_task = (head.slot == task_q);
  assign head_hit  = head.vld && (head.expiry <= count_q);
  assign do_fire   = (state_q == S_POP) && head_hit &&
                     (head_task || (nfire_q < 6'(MAX_FIRED)));

  always_comb begin
    ctl.ins            = acc && (in_req_i.kind == KIND_ARM) && slot_ok &&
                         (cur_st == SLOT_ALLOC);
    ctl.pop            = do_fire;
    ctl.new_ent.vld    = 1'b1;
    ctl.new_ent.slot   = SLOT_W'(sidx);
    ctl.new_ent.expiry = count_q + in_req_i.delay;
  end

  // the sorted chain
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    stq_entry_t left_ent, right_ent;
    logic       left_ge;
    if (g == 0) begin : g_first
      assign left_ent = '0;
      assign left_ge  = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[g-1];
      assign left_ge  = ge[g-1];
    end
    if (g == NUM_TIMERS - 1) begin : g_end
      assign right_ent = '0;
    end else begin : g_nxt
      assign right_ent = ent[g+1];
    end
    stq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .left_i    (left_ent),
      .left_ge_i (left_ge),
      .right_i   (right_ent),
      .ent_o     (ent[g]),
      .ge_o      (ge[g])
    );
  end

  // payload and queue per slot
  stq_ram #(.W(34), .D(NUM_TIMERS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (acc && (in_req_i.kind == KIND_BIND) && slot_ok),
    .waddr_i (sidx),
    .wdata_i ({in_req_i.payload, in_req_i.dest_queue}),
    .re_i    (do_fire && !head_task),
    .raddr_i (head.slot[SW-1:0]),
    .rdata_o (rdata)
  );

  // next result and when it is loaded into the output register
  always_comb begin
    out_load = 1'b0;
    out_d    = '0;
    case (state_q)
      S_IDLE: begin
        out_load       = acc && (in_req_i.kind != KIND_TICK);
        out_d.last     = 1'b1;
        out_d.slot_out = in_req_i.timer_slot;
        case (in_req_i.kind)
          KIND_ALLOC: begin
            if (free_found) begin
              out_d.slot_out = 5'(free_idx);
            end else begin
              out_d.slot_out = '0;
              out_d.status   = STATUS_NO_FREE;
            end
          end
          KIND_FREE: begin
            if (!slot_ok || cur_st == SLOT_ARMED) out_d.status = STATUS_INVALID;
          end
          KIND_BIND: begin
            if (!slot_ok) out_d.status = STATUS_INVALID;
          end
          KIND_ARM: begin
            if (!ctl.ins) out_d.status = STATUS_INVALID;
          end
          KIND_TICK: begin
            out_d.slot_out = '0;
          end
          default: begin
            out_d.status = STATUS_INVALID;
          end
        endcase
      end
      S_EMIT: begin
        out_load            = out_free;
        out_d.status        = STATUS_OK;
        out_d.slot_out      = 5'(fire_slot_q);
        out_d.fired         = 1'b1;
        out_d.fired_payload = rdata[33:2];
        out_d.fired_queue   = rdata[1:0];
      end
      S_FINAL: begin
        out_load         = out_free;
        out_d.switch_req = ts_q;
        out_d.last       = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      nfire_q     <= '0;
      ts_q        <= 1'b0;
      task_q      <= TASK_NONE;
      fire_slot_q <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) slot_st_q[i] <= SLOT_FREE;
    end else begin
      if (cfg_valid_i) task_q <= cfg_data_i;

      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (in_req_i.kind)
              KIND_ALLOC: begin
                if (free_found) slot_st_q[free_idx] <= SLOT_ALLOC;
              end
              KIND_FREE: begin
                if (slot_ok && cur_st != SLOT_ARMED) slot_st_q[sidx] <= SLOT_FREE;
              end
              KIND_ARM: begin
                if (ctl.ins) slot_st_q[sidx] <= SLOT_ARMED;
              end
              KIND_TICK: begin
                count_q <= count_q + 32'd1;
                nfire_q <= '0;
                ts_q    <= 1'b0;
                state_q <= S_POP;
              end
              default: ;
            endcase
          end
        end
        S_POP: begin
          if (do_fire) begin
            slot_st_q[head.slot[SW-1:0]] <= SLOT_ALLOC;
            if (head_task) begin
              ts_q <= 1'b1;
            end else begin
              fire_slot_q <= head.slot[SW-1:0];
              state_q     <= S_EMIT;
            end
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            nfire_q <= nfire_q + 6'd1;
            state_q <= S_POP;
          end
        end
        S_FINAL: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/stq_checker.sv @@
module stq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input stq_pkg::stq_out_t out_res_o
);
  import stq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.fired |-> !out_res_o.last && !out_res_o.switch_req)
    else $error("delivery marked final");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.fired |-> out_res_o.status == STATUS_OK)
    else $error("delivery with error status");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while result pending");
endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

@@ test/tb.sv @@
module tb;
  import stq_pkg::*;

  localparam int NT = 32;
  localparam int LINK_NONE = 63;
  localparam int WATCHDOG = 20000;

  // Scoreboard: own copy of the timer pool, predicts results per request.
  class timer_scoreboard;
    logic [1:0]  st [NT];
    logic [31:0] exp_t [NT];
    logic [31:0] pay [NT];
    logic [1:0]  que [NT];
    int          nxt [NT];
    int          head;
    logic [31:0] count;
    logic [5:0]  task_slot;
    stq_out_t    pending[$];
    int          errors;
    int          fired_seen;

    function void clear();
      for (int i = 0; i < NT; i++) begin
        st[i] = SLOT_FREE; exp_t[i] = '0; pay[i] = '0; que[i] = '0; nxt[i] = 0;
      end
      head = LINK_NONE; count = '0; task_slot = TASK_NONE;
      errors = 0; fired_seen = 0;
    endfunction

    function void push(logic [1:0] s, logic [4:0] sl, logic f, logic [31:0] p,
                       logic [1:0] q, logic ts, logic l);
      stq_out_t r;
      r.status = s; r.slot_out = sl; r.fired = f; r.fired_payload = p;
      r.fired_queue = q; r.switch_req = ts; r.last = l;
      pending.push_back(r);
    endfunction

    function void note_request(stq_in_t req);
      int s, prev, cur, n, g;
      logic [31:0] e;
      logic ts;
      s = req.timer_slot;
      case (req.kind)
        KIND_ALLOC: begin
          for (int i = 0; i < NT; i++)
            if (st[i] == SLOT_FREE) begin
              st[i] = SLOT_ALLOC;
              push(STATUS_OK, 5'(i), 1'b0, '0, '0, 1'b0, 1'b1);
              return;
            end
          push(STATUS_NO_FREE, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end
        KIND_FREE: begin
          if (st[s] == SLOT_ARMED) push(STATUS_INVALID, 5'(s), 1'b0, '0, '0, 1'b0, 1'b1);
          else begin
            st[s] = SLOT_FREE; push(STATUS_OK, 5'(s), 1'b0, '0, '0, 1'b0, 1'b1);
          end
        end
        KIND_BIND: begin
          pay[s] = req.payload; que[s] = req.dest_queue;
          push(STATUS_OK, 5'(s), 1'b0, '0, '0, 1'b0, 1'b1);
        end
        KIND_ARM: begin
          if (st[s] != SLOT_ALLOC) push(STATUS_INVALID, 5'(s), 1'b0, '0, '0, 1'b0, 1'b1);
          else begin
            e = count + req.delay; exp_t[s] = e; st[s] = SLOT_ARMED;
            prev = LINK_NONE; cur = head; g = 0;
            while (cur != LINK_NONE && g < NT && e > exp_t[cur]) begin
              prev = cur; cur = nxt[cur]; g++;
            end
            nxt[s] = cur;
            if (prev != LINK_NONE) nxt[prev] = s; else head = s;
            push(STATUS_OK, 5'(s), 1'b0, '0, '0, 1'b0, 1'b1);
          end
        end
        KIND_TICK: begin
          count = count + 32'd1; n = 0; ts = 1'b0;
          while (head != LINK_NONE && exp_t[head] <= count) begin
            cur = head;
            if (cur != task_slot && n >= MAX_FIRED) break;
            head = nxt[cur]; st[cur] = SLOT_ALLOC;
            if (cur == task_slot) ts = 1'b1;
            else begin
              push(STATUS_OK, 5'(cur), 1'b1, pay[cur], que[cur], 1'b0, 1'b0); n++;
            end
          end
          push(STATUS_OK, '0, 1'b0, '0, '0, ts, 1'b1);
        end
        default: push(STATUS_INVALID, 5'(s), 1'b0, '0, '0, 1'b0, 1'b1);
      endcase
    endfunction

    task check_result(stq_out_t got);
      stq_out_t w;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing outstanding"); return;
      end
      w = pending.pop_front();
      if (got.fired) fired_seen++;
      if (got.status !== w.status) report_mismatch("status");
      if (got.slot_out !== w.slot_out) report_mismatch("slot_out");
      if (got.fired !== w.fired) report_mismatch("fired");
      if (got.fired_payload !== w.fired_payload) report_mismatch("fired_payload");
      if (got.fired_queue !== w.fired_queue) report_mismatch("fired_queue");
      if (got.switch_req !== w.switch_req) report_mismatch("switch_req");
      if (got.last !== w.last) report_mismatch("last");
    endtask

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  stq_in_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  stq_out_t out_res_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [5:0] cfg_data_i = '0;

  timer_scoreboard sb;
  bit quiet;          // no idling in the final stretch
  int idle_cnt;
  int sent;

  sorted_timer_queue_core #(.NUM_TIMERS(NT)) dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Sink side: random stall bursts, sampled at the edge.
  initial begin
    int stall;
    stall = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_res_o);
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 13);
      out_ready_i <= (stall == 0);
    end
  end

  // Watchdog on cycles without any accepted request, result or cfg write.
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // valid stays up after acceptance until the next request replaces it or
  // the caller drops it, so a back-to-back request needs only one update
  task automatic send_request(stq_in_t req);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_req_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    sent++;
  endtask

  task automatic do_cmd(logic [2:0] k, logic [4:0] s, logic [31:0] p,
                        logic [1:0] q, logic [31:0] d);
    stq_in_t r;
    r.kind = k; r.timer_slot = s; r.payload = p; r.dest_queue = q; r.delay = d;
    send_request(r);
  endtask

  // Wait until all results are in, then some extra cycles for the sequencer.
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_task_slot(logic [5:0] v);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.task_slot = v;
    cfg_valid_i <= 0;
  endtask

  // Random request, mostly well-formed against the predictor's view.
  task automatic random_request();
    int r;
    logic [4:0] s;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    s = 5'($urandom_range(0, NT - 1));
    for (int i = 0; i < 4; i++)
      if (sb.st[s] == SLOT_FREE && r >= 20) s = 5'($urandom_range(0, NT - 1));
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, 3);
      1: d = $urandom_range(0, 12);
      2: d = $urandom;
      default: d = $urandom_range(0, 6);
    endcase
    if (r < 16) do_cmd(KIND_ALLOC, s, $urandom, 2'($urandom), $urandom);
    else if (r < 24) do_cmd(KIND_FREE, s, $urandom, 2'($urandom), $urandom);
    else if (r < 38) do_cmd(KIND_BIND, s, $urandom, 2'($urandom), $urandom);
    else if (r < 62) begin
      // bind first so a later firing never delivers unbound content
      if (sb.st[s] == SLOT_ALLOC) do_cmd(KIND_BIND, s, $urandom, 2'($urandom), $urandom);
      do_cmd(KIND_ARM, s, $urandom, 2'($urandom), d);
    end
    else if (r < 96) do_cmd(KIND_TICK, s, $urandom, 2'($urandom), $urandom);
    else do_cmd(3'($urandom_range(5, 7)), s, $urandom, 2'($urandom), $urandom);
  endtask

  initial begin
    logic [5:0] task_vals [4];
    sb = new();
    sb.clear();
    quiet = 0;
    sent = 0;
    task_vals = '{6'd0, 6'd31, 6'd63, 6'd5};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: every kind, pool exhaustion, error cases, ties, far expiry.
    do_cmd(KIND_FREE, 5'd0, 32'd0, 2'd0, 32'd0);          // free of a free timer
    do_cmd(KIND_ARM, 5'd3, 32'd0, 2'd0, 32'd5);           // arm of a free timer
    for (int i = 0; i < 33; i++)
      do_cmd(KIND_ALLOC, 5'd0, 32'd0, 2'd0, 32'd0);       // last one fails
    do_cmd(KIND_BIND, 5'd31, 32'hffffffff, 2'd3, 32'd0);
    do_cmd(KIND_BIND, 5'd0, 32'h0, 2'd0, 32'd0);
    do_cmd(KIND_BIND, 5'd7, 32'ha5a5_5a5a, 2'd2, 32'd0);
    do_cmd(KIND_ARM, 5'd31, 32'd0, 2'd0, 32'd2);
    do_cmd(KIND_ARM, 5'd0, 32'd0, 2'd0, 32'd2);           // tie: fires before slot 31
    do_cmd(KIND_ARM, 5'd0, 32'd0, 2'd0, 32'd2);           // already armed
    do_cmd(KIND_FREE, 5'd0, 32'd0, 2'd0, 32'd0);          // free of armed
    do_cmd(KIND_ARM, 5'd7, 32'd0, 2'd0, 32'hffffffff);    // far expiry
    do_cmd(3'd7, 5'd9, 32'd0, 2'd0, 32'd0);               // unknown kind
    do_cmd(3'd5, 5'd10, 32'd0, 2'd0, 32'd0);
    do_cmd(KIND_TICK, 5'd0, 32'd0, 2'd0, 32'd0);
    do_cmd(KIND_TICK, 5'd0, 32'd0, 2'd0, 32'd0);
    do_cmd(KIND_ARM, 5'd0, 32'd0, 2'd0, 32'd0);           // zero delay fires next tick
    do_cmd(KIND_TICK, 5'd0, 32'd0, 2'd0, 32'd0);
    do_cmd(KIND_FREE, 5'd0, 32'd0, 2'd0, 32'd0);
    drain();

    // Random phases over several task-slot settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_task_slot(task_vals[ph]);
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 34; i++) random_request();
      // many expiries in one tick
      if (ph == 1) begin
        for (int i = 0; i < NT; i++)
          if (sb.st[i] == SLOT_ALLOC) begin
            do_cmd(KIND_BIND, 5'(i), $urandom, 2'($urandom), 32'd0);
            do_cmd(KIND_ARM, 5'(i), 32'd0, 2'd0, 32'd1);
          end
        do_cmd(KIND_TICK, 5'd0, 32'd0, 2'd0, 32'd0);
      end
      drain();
    end
    write_task_slot(TASK_NONE);

    $display("Ran %0d requests across 5 task-slot settings, %0d timer deliveries.",
             sent, sb.fired_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
